@@ design/rrtt_pkg.sv @@
// Package for the round-robin task table: payload structs, state codes,
// command codes and sequencer states. No dependencies.
`default_nettype none
package rrtt_pkg;

  typedef enum logic [2:0] {
    FN_CREATE  = 3'd0,
    FN_TICK    = 3'd1,
    FN_YIELD   = 3'd2,
    FN_UNBLOCK = 3'd3,
    FN_BLOCK   = 3'd4,
    FN_QUERY   = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_BLOCKED = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_RD_RUN,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DSP_REL,
    S_DSP_RD,
    S_DSP_CHK,
    S_FIN_RD,
    S_FIN_WAIT,
    S_DONE
  } fsm_e;

  localparam logic [7:0] QUANTUM_RESET = 8'd10;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] target_pid;
    logic [31:0] sleep_ticks;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] task_pid;
    logic [7:0]  task_slot;
    logic [1:0]  task_state;
    logic [7:0]  running_slot;
    logic [31:0] running_pid;
    logic        switched;
    logic [63:0] tick_total;
  } rsp_t;

  // one table entry: used bit, status, id, sleep count
  typedef struct packed {
    logic        used;
    logic [1:0]  status;
    logic [31:0] id;
    logic [31:0] sleep;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage
`default_nettype wire

@@ design/rrtt_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module rrtt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

@@ design/round_robin_task_table.sv @@
// Top level of the round-robin task table: command sequencer over one
// table RAM. Depends on rrtt_pkg and rrtt_ram.
//
// Create, unblock, query and tick scan the table; a tick that ends a quantum
// adds a dispatch walk, and block and yield walk for dispatch as well. Each
// walk visits the slots one at a time through the single RAM port, a read
// state then a check state per slot. busy is high from the accept edge through
// the strobe, so the next transaction can be accepted in the cycle after it; the
// receiver cannot stall results. After reset a clearing pass over every slot runs with busy high.
`default_nettype none
module round_robin_task_table #(
  parameter int unsigned SLOTS = 256
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire rrtt_pkg::cmd_t cmd_i,
  input  wire logic           cfg_we_i,
  input  wire logic [7:0]     cfg_wdata_i,
  output logic                rsp_valid_o,
  output rrtt_pkg::rsp_t      rsp_o
);
  import rrtt_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] SlotsC = CW'(SLOTS);
  localparam logic [AW-1:0] LastSlot = AW'(SLOTS - 1);

  fsm_e state_q, state_d;
  logic [AW-1:0] run_q, run_d, before_q, before_d;
  logic [31:0] idc_q, idc_d;
  logic [CW-1:0] live_q, live_d;
  logic [63:0] tick_q, tick_d;
  logic [7:0] qcnt_q, qcnt_d, quantum_q;
  cmd_t cmd_q, cmd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic ok_q, ok_d, found_q, found_d, fb_q, fb_d, dsp_q, dsp_d;
  logic [AW-1:0] task_q, task_d, fbs_q, fbs_d;
  logic [31:0] runpid_q, runpid_d;

  logic          we;
  logic [AW-1:0] addr;
  entry_t        wdata, rdata;

  rrtt_ram #(.Width(EntryW), .Depth(SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      run_q     <= '0;
      before_q  <= '0;
      idc_q     <= 32'd2;
      live_q    <= CW'(1);
      tick_q    <= '0;
      qcnt_q    <= '0;
      quantum_q <= QUANTUM_RESET;
      cnt_q     <= '0;
      ptr_q     <= '0;
      ok_q      <= 1'b0;
      found_q   <= 1'b0;
      fb_q      <= 1'b0;
      dsp_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      run_q    <= run_d;
      before_q <= before_d;
      idc_q    <= idc_d;
      live_q   <= live_d;
      tick_q   <= tick_d;
      qcnt_q   <= qcnt_d;
      cnt_q    <= cnt_d;
      ptr_q    <= ptr_d;
      ok_q     <= ok_d;
      found_q  <= found_d;
      fb_q     <= fb_d;
      dsp_q    <= dsp_d;
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    task_q   <= task_d;
    fbs_q    <= fbs_d;
    runpid_q <= runpid_d;
  end

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] s);
    nxt = (s == LastSlot) ? '0 : s + AW'(1);
  endfunction

  always_comb begin
    entry_t e;
    logic last;
    logic [7:0] qn;
    e = rdata;
    state_d  = state_q;
    run_d    = run_q;
    before_d = before_q;
    idc_d    = idc_q;
    live_d   = live_q;
    tick_d   = tick_q;
    qcnt_d   = qcnt_q;
    cmd_d    = cmd_q;
    cnt_d    = cnt_q;
    ptr_d    = ptr_q;
    ok_d     = ok_q;
    found_d  = found_q;
    fb_d     = fb_q;
    dsp_d    = dsp_q;
    task_d   = task_q;
    fbs_d    = fbs_q;
    runpid_d = runpid_q;
    we       = 1'b0;
    addr     = ptr_q;
    wdata    = rdata;
    busy     = 1'b1;
    rsp_valid_o = 1'b0;
    last     = (cnt_q == SlotsC - CW'(1));
    qn       = qcnt_q + 8'd1;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        wdata = '0;
        if (ptr_q == '0) begin
          wdata.used = 1'b1;
          wdata.id = 32'd1;
          wdata.status = ST_RUNNING;
        end
        ptr_d = nxt(ptr_q);
        if (ptr_q == LastSlot) state_d = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_d = cmd_i;
          before_d = run_q;
          ok_d = 1'b0;
          found_d = 1'b0;
          fb_d = 1'b0;
          dsp_d = 1'b0;
          cnt_d = '0;
          ptr_d = '0;
          task_d = '0;
          fbs_d = '0;
          state_d = S_SCAN_RD;
          unique case (cmd_i.func)
            FN_CREATE: if (live_q >= SlotsC) state_d = S_FIN_RD;
            FN_TICK: begin
              tick_d = tick_q + 64'd1;
              ok_d = 1'b1;
              qcnt_d = qn;
              if (qn >= quantum_q) begin
                qcnt_d = '0;
                dsp_d = 1'b1;
              end
            end
            FN_YIELD: begin
              ok_d = 1'b1;
              dsp_d = 1'b1;
              state_d = S_DSP_REL;
            end
            FN_UNBLOCK, FN_QUERY: ;
            FN_BLOCK: begin
              found_d = 1'b1;
              task_d = run_q;
              state_d = S_RD_RUN;
            end
            default: state_d = S_FIN_RD;
          endcase
        end
      end
      S_RD_RUN: begin
        addr = run_q;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_RD: state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        state_d = S_SCAN_RD;
        ptr_d = nxt(ptr_q);
        cnt_d = cnt_q + CW'(1);
        unique case (cmd_q.func)
          FN_CREATE: begin
            if (!e.used) begin
              we = 1'b1;
              wdata = '0;
              wdata.used = 1'b1;
              wdata.id = idc_q;
              wdata.status = ST_READY;
              idc_d = (idc_q == 32'hFFFF_FFFF) ? 32'd1 : idc_q + 32'd1;
              live_d = live_q + CW'(1);
              ok_d = 1'b1;
              found_d = 1'b1;
              task_d = ptr_q;
              state_d = S_FIN_RD;
            end else if (last) state_d = S_FIN_RD;
          end
          FN_TICK: begin
            if (e.used && e.status == ST_BLOCKED && e.sleep != '0) begin
              we = 1'b1;
              wdata.sleep = e.sleep - 32'd1;
              if (e.sleep == 32'd1) wdata.status = ST_READY;
            end
            if (last) state_d = dsp_q ? S_DSP_REL : S_FIN_RD;
          end
          FN_UNBLOCK: begin
            if (e.used && e.id == cmd_q.target_pid && !fb_q) begin
              fb_d = 1'b1;
              fbs_d = ptr_q;
            end
            if (e.used && e.id == cmd_q.target_pid && e.status == ST_BLOCKED) begin
              we = 1'b1;
              wdata.status = ST_READY;
              ok_d = 1'b1;
              found_d = 1'b1;
              task_d = ptr_q;
              state_d = S_FIN_RD;
            end else if (last) begin
              found_d = fb_d;
              task_d = fbs_d;
              state_d = S_FIN_RD;
            end
          end
          FN_BLOCK: begin
            addr = run_q;
            ptr_d = ptr_q;
            if (e.status == ST_RUNNING) begin
              we = 1'b1;
              wdata.status = ST_BLOCKED;
              wdata.sleep = cmd_q.sleep_ticks;
              ok_d = 1'b1;
              dsp_d = 1'b1;
              state_d = S_DSP_RD;
              ptr_d = nxt(run_q);
              cnt_d = '0;
            end else state_d = S_FIN_RD;
          end
          default: begin
            if (e.used && e.id == cmd_q.target_pid) begin
              ok_d = 1'b1;
              found_d = 1'b1;
              task_d = ptr_q;
              state_d = S_FIN_RD;
            end else if (last) state_d = S_FIN_RD;
          end
        endcase
      end
      S_DSP_REL: begin
        // read run slot, then release it if running
        addr = run_q;
        ptr_d = run_q;
        cnt_d = '0;
        state_d = S_DSP_RD;
        fb_d = 1'b1;
      end
      S_DSP_RD: begin
        state_d = S_DSP_CHK;
      end
      S_DSP_CHK: begin
        state_d = S_DSP_RD;
        if (fb_q) begin
          fb_d = 1'b0;
          if (e.status == ST_RUNNING) begin
            we = 1'b1;
            wdata.status = ST_READY;
          end
          ptr_d = nxt(run_q);
        end else begin
          ptr_d = nxt(ptr_q);
          cnt_d = cnt_q + CW'(1);
          if (e.used && e.status == ST_READY) begin
            we = 1'b1;
            wdata.status = ST_RUNNING;
            run_d = ptr_q;
            state_d = S_FIN_RD;
          end else if (last) state_d = S_FIN_RD;
        end
      end
      S_FIN_RD: begin
        addr = run_q;
        state_d = S_FIN_WAIT;
      end
      S_FIN_WAIT: begin
        addr = task_q;
        runpid_d = rdata.id;
        state_d = S_DONE;
      end
      S_DONE: begin
        addr = task_q;
        rsp_valid_o = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_o = '0;
    rsp_o.ok = ok_q;
    if (found_q) begin
      rsp_o.task_pid = rdata.id;
      rsp_o.task_slot = 8'(task_q);
      rsp_o.task_state = rdata.status;
    end
    rsp_o.running_slot = 8'(run_q);
    rsp_o.running_pid = runpid_q;
    rsp_o.switched = (run_q != before_q);
    rsp_o.tick_total = tick_q;
  end

`ifndef SYNTH
  a_busy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !busy) else $error("busy while idle");
  a_rsp_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o) else $error("double result");
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= SlotsC) else $error("live count overflow");
  a_run_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> (run_q == $past(run_q))) else $error("run moved");
`endif

endmodule
`default_nettype wire
